FILE: design/ccl_pkg.sv
// Shared types, character codes and decode helpers for the numeric literal classifier.
package ccl_pkg;

  // Scan phase of the current token, one-hot coded.
  typedef enum logic [12:0] {
    PH_START   = 13'b0000000000001,
    PH_ZERO    = 13'b0000000000010,
    PH_HEX     = 13'b0000000000100,
    PH_INT     = 13'b0000000001000,
    PH_FRAC    = 13'b0000000010000,
    PH_EXPSIGN = 13'b0000000100000,
    PH_EXPDIG  = 13'b0000001000000,
    PH_FDONE   = 13'b0000010000000,
    PH_U       = 13'b0000100000000,
    PH_UL      = 13'b0001000000000,
    PH_L       = 13'b0010000000000,
    PH_LL      = 13'b0100000000000,
    PH_TAIL    = 13'b1000000000000
  } phase_t;

  typedef logic [3:0] cls_t;
  typedef logic [7:0] char_t;

  localparam cls_t CL_INT   = 4'd0;
  localparam cls_t CL_UINT  = 4'd1;
  localparam cls_t CL_LONG  = 4'd2;
  localparam cls_t CL_ULONG = 4'd3;
  localparam cls_t CL_LL    = 4'd4;
  localparam cls_t CL_ULL   = 4'd5;
  localparam cls_t CL_DBL   = 4'd6;
  localparam cls_t CL_FLT   = 4'd7;
  localparam cls_t CL_LDBL  = 4'd8;
  localparam cls_t CL_NONE  = 4'd9;

  localparam char_t CH_ZERO  = 8'h30;  // '0'
  localparam char_t CH_SEVEN = 8'h37;  // '7'
  localparam char_t CH_NINE  = 8'h39;  // '9'
  localparam char_t CH_DOT   = 8'h2e;  // '.'
  localparam char_t CH_PLUS  = 8'h2b;  // '+'
  localparam char_t CH_MINUS = 8'h2d;  // '-'
  localparam char_t CH_LO_A  = 8'h61;  // 'a'
  localparam char_t CH_LO_E  = 8'h65;  // 'e'
  localparam char_t CH_LO_F  = 8'h66;  // 'f'
  localparam char_t CH_LO_L  = 8'h6c;  // 'l'
  localparam char_t CH_LO_U  = 8'h75;  // 'u'
  localparam char_t CH_LO_X  = 8'h78;  // 'x'
  localparam char_t CASE_BIT = 8'h20;

  // Outcome of one character: next phase, class so far and an error to record.
  typedef struct packed {
    phase_t phase;
    cls_t   cls;
    logic   set_err;
  } step_t;

  function automatic logic is_dec(char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hexd(char_t c);
    char_t l;
    l = c | CASE_BIT;
    return is_dec(c) || ((l >= CH_LO_A) && (l <= CH_LO_F));
  endfunction

  function automatic logic is_letter(char_t c, char_t lower);
    return (c | CASE_BIT) == lower;
  endfunction

  // First character after an integer digit run.
  function automatic step_t int_suffix_start(char_t c);
    step_t s;
    if (is_letter(c, CH_LO_U)) begin
      s = '{PH_U, CL_UINT, 1'b0};
    end else if (is_letter(c, CH_LO_L)) begin
      s = '{PH_L, CL_LONG, 1'b0};
    end else begin
      s = '{PH_TAIL, CL_INT, 1'b1};
    end
    return s;
  endfunction

  // First character after a fraction or an exponent.
  function automatic step_t float_suffix(char_t c);
    step_t s;
    if (is_letter(c, CH_LO_F)) begin
      s = '{PH_FDONE, CL_FLT, 1'b0};
    end else if (is_letter(c, CH_LO_L)) begin
      s = '{PH_FDONE, CL_LDBL, 1'b0};
    end else begin
      s = '{PH_TAIL, CL_NONE, 1'b1};
    end
    return s;
  endfunction

  // Character in the leading decimal digit run, or just after it.
  function automatic step_t int_run(char_t c, cls_t cur);
    step_t s;
    if (is_dec(c)) begin
      s = '{PH_INT, cur, 1'b0};
    end else if (c == CH_DOT) begin
      s = '{PH_FRAC, CL_DBL, 1'b0};
    end else if (is_letter(c, CH_LO_E)) begin
      s = '{PH_EXPSIGN, CL_DBL, 1'b0};
    end else begin
      s = int_suffix_start(c);
    end
    return s;
  endfunction

endpackage

FILE: design/c_numeric_literal_classifier.sv
// Top level: per-character scanner that classifies a C numeric constant token.
//
//   Channel  Direction  Signals                                    Meaning
//   in_      input      in_valid/in_ready, in_char_code,           one token character
//                       in_last_char
//   out_     output     out_valid/out_ready, out_const_class,      class of a finished token
//                       out_invalid
//
// One character is taken per cycle while in_ready is high; the scan state updates at the same edge.
// The class of a token is registered at the edge that takes its last character.
// Reset is synchronous, active low, and returns the scanner to the token start.
// A two-entry result buffer (output register plus skid) keeps input flowing while
// a result waits; in_ready drops only when both entries hold results.
module c_numeric_literal_classifier (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_char_code,
  input  logic            in_last_char,
  output logic            out_valid,
  input  logic            out_ready,
  output ccl_pkg::cls_t   out_const_class,
  output logic            out_invalid
);
  import ccl_pkg::*;

  phase_t phase_r, phase_nxt;
  cls_t   class_r, class_nxt;
  logic   lz_r, lz_nxt;
  logic   nonoct_r, nonoct_nxt;
  logic   err_r, err_nxt;

  logic   out_valid_r;
  cls_t   out_class_r;
  logic   out_inv_r;
  logic   skid_valid_r;
  cls_t   skid_class_r;
  logic   skid_inv_r;

  step_t  st;
  logic   oct_bad;
  cls_t   res_class;
  logic   res_inv;
  logic   in_fire;
  logic   out_fire;
  logic   produce;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign produce   = in_fire && in_last_char;

  always_comb begin
    st = '{phase_r, class_r, 1'b0};
    unique case (phase_r)
      PH_START: begin
        if (in_char_code == CH_ZERO) begin
          st.phase = PH_ZERO;
        end else begin
          st = int_run(in_char_code, class_r);
        end
      end
      PH_ZERO: begin
        if (is_letter(in_char_code, CH_LO_X)) begin
          st.phase = PH_HEX;
        end else begin
          st = int_run(in_char_code, class_r);
        end
      end
      PH_HEX: begin
        if (!is_hexd(in_char_code)) begin
          st = int_suffix_start(in_char_code);
        end
      end
      PH_INT: begin
        st = int_run(in_char_code, class_r);
      end
      PH_FRAC: begin
        if (is_letter(in_char_code, CH_LO_E)) begin
          st.phase = PH_EXPSIGN;
        end else if (!is_dec(in_char_code)) begin
          st = float_suffix(in_char_code);
        end
      end
      PH_EXPSIGN: begin
        if (in_char_code == CH_PLUS || in_char_code == CH_MINUS || is_dec(in_char_code)) begin
          st.phase = PH_EXPDIG;
        end else begin
          st = float_suffix(in_char_code);
        end
      end
      PH_EXPDIG: begin
        if (!is_dec(in_char_code)) begin
          st = float_suffix(in_char_code);
        end
      end
      PH_U: begin
        if (is_letter(in_char_code, CH_LO_L)) begin
          st.phase = PH_UL;
          st.cls   = CL_ULONG;
        end else begin
          st.phase   = PH_TAIL;
          st.set_err = 1'b1;
        end
      end
      PH_UL: begin
        st.phase = PH_TAIL;
        if (is_letter(in_char_code, CH_LO_L)) begin
          st.cls = CL_ULL;
        end else begin
          st.set_err = 1'b1;
        end
      end
      PH_L: begin
        if (is_letter(in_char_code, CH_LO_L)) begin
          st.phase = PH_LL;
          st.cls   = CL_LL;
        end else begin
          st.phase = PH_TAIL;
          if (is_letter(in_char_code, CH_LO_U)) begin
            st.cls = CL_ULONG;
          end else begin
            st.set_err = 1'b1;
          end
        end
      end
      PH_LL: begin
        st.phase = PH_TAIL;
        if (is_letter(in_char_code, CH_LO_U)) begin
          st.cls = CL_ULL;
        end else begin
          st.set_err = 1'b1;
        end
      end
      default: begin
        // Anything after a float suffix or a finished integer suffix is trailing junk.
        st.set_err = 1'b1;
      end
    endcase

    phase_nxt  = st.phase;
    class_nxt  = st.cls;
    err_nxt    = err_r | st.set_err;
    lz_nxt     = lz_r | ((phase_r == PH_START) && (in_char_code == CH_ZERO));
    nonoct_nxt = nonoct_r
               | (((phase_r == PH_START) || (phase_r == PH_ZERO) || (phase_r == PH_INT))
                  && is_dec(in_char_code) && (in_char_code > CH_SEVEN));

    // An octal integer with an 8 or 9 overrides whatever suffix came after it.
    oct_bad   = (class_nxt < CL_DBL) && lz_nxt && nonoct_nxt;
    res_class = oct_bad ? CL_INT : class_nxt;
    res_inv   = err_nxt | oct_bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      class_r  <= CL_INT;
      lz_r     <= 1'b0;
      nonoct_r <= 1'b0;
      err_r    <= 1'b0;
    end else if (in_fire) begin
      if (in_last_char) begin
        phase_r  <= PH_START;
        class_r  <= CL_INT;
        lz_r     <= 1'b0;
        nonoct_r <= 1'b0;
        err_r    <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        class_r  <= class_nxt;
        lz_r     <= lz_nxt;
        nonoct_r <= nonoct_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_class_r <= skid_class_r;
        out_inv_r   <= skid_inv_r;
      end
    end else if (produce) begin
      if (!out_valid_r || out_fire) begin
        out_class_r <= res_class;
        out_inv_r   <= res_inv;
      end else begin
        skid_class_r <= res_class;
        skid_inv_r   <= res_inv;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_const_class = out_class_r;
  assign out_invalid     = out_inv_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_class_r <= CL_NONE))
    else $error("result class out of range");

  a_unclassified_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_class_r == CL_NONE)) |-> out_inv_r)
    else $error("unclassified token not flagged invalid");

  a_token_restart: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> (phase_r == PH_START) && !err_r && !lz_r && !nonoct_r)
    else $error("scanner did not return to token start after last character");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && !out_valid_r) |=> out_valid_r && !skid_valid_r)
    else $error("result into an empty buffer did not reach the output register");

endmodule
